// File: sv/lfe_pkg.sv
// lfe_pkg: shared types and constants of the led strip frame encoder
// no dependencies; used by scoped names in every module of the encoder but lfe_ram
package lfe_pkg;

	localparam int COLOR_W     = 24;
	localparam int IDX_W       = 8;
	localparam int CNT_W       = 7;
	localparam int SYM_W       = 9;
	localparam int BIT_PTR_W   = 5;
	localparam int TAIL_W      = 4;
	localparam int BITS_PER_LED = 24;

	localparam logic [SYM_W-1:0] SYM_ONE  = 9'h1F8;
	localparam logic [SYM_W-1:0] SYM_ZERO = 9'h1C0;
	localparam logic [SYM_W-1:0] SYM_TAIL = 9'h000;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [2:0] {
		FN_SET_ONE   = 3'd0,
		FN_SET_ALL   = 3'd1,
		FN_LIGHT_ONE = 3'd2,
		FN_START     = 3'd3,
		FN_PULL      = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DATA = 2'd1,
		PH_TAIL = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_FILL,
		CS_COPY,
		CS_PULL_RD,
		CS_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0]         func;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] color;
	} item_t;

	typedef struct packed {
		logic               status;
		logic [SYM_W-1:0]   symbol;
		logic               sym_valid;
		logic               last;
	} result_t;

	// request to the color store; addresses are full index width
	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		logic [COLOR_W-1:0] wdata;
		logic [IDX_W-1:0]   raddr;
	} cs_req_t;

endpackage

// File: sv/lfe_ram.sv
// lfe_ram: generic single write port, single read port ram with registered read
// no dependencies
module lfe_ram #(
	parameter int Width = 24,
	parameter int Depth = 64,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/lfe_color_store.sv
// lfe_color_store: color store ram with per-entry valid bits, unwritten entries read as zero
// depends on lfe_pkg and lfe_ram
module lfe_color_store #(
	parameter int MAX_LEDS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfe_pkg::cs_req_t              req,
	output logic [lfe_pkg::COLOR_W-1:0]   rdata
);

	localparam int AddrW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	logic [AddrW-1:0]            waddr;
	logic [AddrW-1:0]            raddr;
	logic [lfe_pkg::COLOR_W-1:0] ram_rdata;
	logic [MAX_LEDS-1:0]         vld_q;
	logic                        vld_s1;

	assign waddr = AddrW'(req.waddr);
	assign raddr = AddrW'(req.raddr);

	lfe_ram #(
		.Width(lfe_pkg::COLOR_W),
		.Depth(MAX_LEDS)
	) u_ram (
		.clk  (clk),
		.we   (req.we),
		.waddr(waddr),
		.wdata(req.wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[waddr] <= 1'b1;
			end
			vld_s1 <= vld_q[raddr];
		end
	end

	assign rdata = vld_s1 ? ram_rdata : '0;

endmodule

// File: sv/lfe_ctrl.sv
// lfe_ctrl: command sequencer, fill and copy sweeps, snapshot ram and symbol serializer
// depends on lfe_pkg and lfe_ram
module lfe_ctrl #(
	parameter int MAX_LEDS    = 64,
	parameter int TAIL_FRAMES = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lfe_pkg::item_t              item,
	input  logic [lfe_pkg::CNT_W-1:0]   num_leds,
	output lfe_pkg::cs_req_t            cs_req,
	input  logic [lfe_pkg::COLOR_W-1:0] cs_rdata,
	output logic                        res_valid,
	input  logic                        res_ready,
	output lfe_pkg::result_t            res
);

	localparam int AddrW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam logic [8:0] MaxLeds9 = 9'(MAX_LEDS);
	localparam logic [4:0] TailFrames5 = 5'(TAIL_FRAMES);

	lfe_pkg::ctrl_state_t state_q, state_d;
	lfe_pkg::phase_t      phase_q;

	logic [AddrW-1:0]                ptr_q;
	logic [AddrW-1:0]                led_ptr_q;
	logic [lfe_pkg::BIT_PTR_W-1:0]   bit_ptr_q;
	logic [lfe_pkg::TAIL_W-1:0]      tail_q;
	logic [lfe_pkg::CNT_W-1:0]       frame_len_q;
	logic [2:0]                      func_q;
	logic [lfe_pkg::IDX_W-1:0]       idx_q;
	logic [lfe_pkg::COLOR_W-1:0]     color_q;
	lfe_pkg::result_t                res_q;
	lfe_pkg::result_t                acc_res;

	logic                            cp_we_s1;
	logic [AddrW-1:0]                cp_addr_s1;
	logic [lfe_pkg::COLOR_W-1:0]     snap_rdata;

	logic                            acc;
	logic                            idx_ok;
	logic                            cnt_big;
	logic                            cnt_zero;
	logic                            sweep_end;
	logic [4:0]                      tail_nx;
	logic                            tail_end;
	logic [8:0]                      led_nx;
	logic                            data_bit;
	logic [lfe_pkg::BIT_PTR_W-1:0]   bit_sel;

	assign acc      = in_valid && in_ready;
	assign idx_ok   = {1'b0, item.idx} < MaxLeds9;
	assign cnt_big  = 9'(num_leds) > MaxLeds9;
	assign cnt_zero = (num_leds == '0);
	assign sweep_end = (9'(ptr_q) == (9'(num_leds) - 9'd1));
	assign tail_nx  = 5'(tail_q) + 5'd1;
	assign tail_end = (tail_nx >= TailFrames5);
	assign led_nx   = 9'(led_ptr_q) + 9'd1;
	assign bit_sel  = lfe_pkg::BIT_PTR_W'(lfe_pkg::BITS_PER_LED - 1) - bit_ptr_q;
	assign data_bit = snap_rdata[bit_sel];

	// snapshot store, written by the copy sweep in the cycle after each color read
	lfe_ram #(
		.Width(lfe_pkg::COLOR_W),
		.Depth(MAX_LEDS)
	) u_snap_ram (
		.clk  (clk),
		.we   (cp_we_s1),
		.waddr(cp_addr_s1),
		.wdata(cs_rdata),
		.raddr(led_ptr_q),
		.rdata(snap_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lfe_pkg::CS_IDLE: begin
				if (acc) begin
					case (lfe_pkg::func_t'(item.func))
						lfe_pkg::FN_SET_ALL, lfe_pkg::FN_LIGHT_ONE: begin
							state_d = (cnt_big || cnt_zero) ? lfe_pkg::CS_DONE
							                                 : lfe_pkg::CS_FILL;
						end
						lfe_pkg::FN_START: begin
							state_d = (phase_q != lfe_pkg::PH_IDLE || cnt_zero || cnt_big)
							        ? lfe_pkg::CS_DONE : lfe_pkg::CS_COPY;
						end
						lfe_pkg::FN_PULL: begin
							state_d = (phase_q == lfe_pkg::PH_DATA) ? lfe_pkg::CS_PULL_RD
							                                        : lfe_pkg::CS_DONE;
						end
						default: begin
							state_d = lfe_pkg::CS_DONE;
						end
					endcase
				end
			end
			lfe_pkg::CS_FILL, lfe_pkg::CS_COPY: begin
				if (sweep_end) begin
					state_d = lfe_pkg::CS_DONE;
				end
			end
			lfe_pkg::CS_PULL_RD: begin
				state_d = lfe_pkg::CS_DONE;
			end
			lfe_pkg::CS_DONE: begin
				if (res_ready) begin
					state_d = lfe_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = lfe_pkg::CS_IDLE;
			end
		endcase
	end

	// outputs and memory requests
	always_comb begin
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		cs_req.we     = 1'b0;
		cs_req.waddr  = item.idx;
		cs_req.wdata  = item.color;
		cs_req.raddr  = lfe_pkg::IDX_W'(ptr_q);
		case (state_q)
			lfe_pkg::CS_IDLE: begin
				in_ready  = 1'b1;
				cs_req.we = acc && idx_ok
				         && (lfe_pkg::func_t'(item.func) == lfe_pkg::FN_SET_ONE);
			end
			lfe_pkg::CS_FILL: begin
				cs_req.we    = 1'b1;
				cs_req.waddr = lfe_pkg::IDX_W'(ptr_q);
				cs_req.wdata = ((lfe_pkg::func_t'(func_q) == lfe_pkg::FN_LIGHT_ONE)
				                && (9'(ptr_q) != 9'(idx_q))) ? '0 : color_q;
			end
			lfe_pkg::CS_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// result of an accepted request; a data pull gets its frame in the following cycle
	always_comb begin
		acc_res        = '0;
		acc_res.status = lfe_pkg::STATUS_OK;
		acc_res.symbol = lfe_pkg::SYM_TAIL;
		case (lfe_pkg::func_t'(item.func))
			lfe_pkg::FN_SET_ONE: begin
				acc_res.status = idx_ok ? lfe_pkg::STATUS_OK : lfe_pkg::STATUS_ERR;
			end
			lfe_pkg::FN_SET_ALL, lfe_pkg::FN_LIGHT_ONE: begin
				acc_res.status = cnt_big ? lfe_pkg::STATUS_ERR : lfe_pkg::STATUS_OK;
			end
			lfe_pkg::FN_START: begin
				acc_res.status = (phase_q != lfe_pkg::PH_IDLE || cnt_zero || cnt_big)
				               ? lfe_pkg::STATUS_ERR : lfe_pkg::STATUS_OK;
			end
			lfe_pkg::FN_PULL: begin
				if (phase_q == lfe_pkg::PH_TAIL) begin
					acc_res.sym_valid = 1'b1;
					acc_res.last      = tail_end;
				end else if (phase_q == lfe_pkg::PH_IDLE) begin
					acc_res.status = lfe_pkg::STATUS_ERR;
				end
			end
			default: begin
				acc_res.status = lfe_pkg::STATUS_ERR;
			end
		endcase
	end

	assign res = res_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfe_pkg::CS_IDLE;
			phase_q     <= lfe_pkg::PH_IDLE;
			ptr_q       <= '0;
			led_ptr_q   <= '0;
			bit_ptr_q   <= '0;
			tail_q      <= '0;
			frame_len_q <= '0;
			cp_we_s1    <= 1'b0;
		end else begin
			state_q  <= state_d;
			cp_we_s1 <= (state_q == lfe_pkg::CS_COPY);
			case (state_q)
				lfe_pkg::CS_IDLE: begin
					ptr_q <= '0;
					if (acc) begin
						case (lfe_pkg::func_t'(item.func))
							lfe_pkg::FN_START: begin
								if (phase_q == lfe_pkg::PH_IDLE && !cnt_zero && !cnt_big) begin
									frame_len_q <= num_leds;
									phase_q     <= lfe_pkg::PH_DATA;
									led_ptr_q   <= '0;
									bit_ptr_q   <= '0;
									tail_q      <= '0;
								end
							end
							lfe_pkg::FN_PULL: begin
								if (phase_q == lfe_pkg::PH_TAIL) begin
									if (tail_end) begin
										tail_q  <= '0;
										phase_q <= lfe_pkg::PH_IDLE;
									end else begin
										tail_q <= lfe_pkg::TAIL_W'(tail_nx);
									end
								end
							end
							default: begin
								phase_q <= phase_q;
							end
						endcase
					end
				end
				lfe_pkg::CS_FILL, lfe_pkg::CS_COPY: begin
					ptr_q <= ptr_q + AddrW'(1);
				end
				lfe_pkg::CS_PULL_RD: begin
					if (bit_ptr_q == lfe_pkg::BIT_PTR_W'(lfe_pkg::BITS_PER_LED - 1)) begin
						bit_ptr_q <= '0;
						if (led_nx >= 9'(frame_len_q)) begin
							led_ptr_q <= '0;
							phase_q   <= lfe_pkg::PH_TAIL;
							tail_q    <= '0;
						end else begin
							led_ptr_q <= AddrW'(led_nx);
						end
					end else begin
						bit_ptr_q <= bit_ptr_q + 1'b1;
					end
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
		end
	end

	// payload: latched command, copy write address, pending result
	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q;
		if (acc) begin
			func_q  <= item.func;
			idx_q   <= item.idx;
			color_q <= item.color;
			res_q   <= acc_res;
		end else if (state_q == lfe_pkg::CS_PULL_RD) begin
			res_q <= '{
				status:    lfe_pkg::STATUS_OK,
				symbol:    data_bit ? lfe_pkg::SYM_ONE : lfe_pkg::SYM_ZERO,
				sym_valid: 1'b1,
				last:      1'b0
			};
		end
	end

endmodule

// File: sv/led_strip_frame_encoder_unit.sv
// led strip frame encoder: a result reaches the output register through the result state once
// its request is accepted; a data pull first reads its bit from the snapshot ram, and a set all,
// light only one or refresh start that passes its checks first sweeps the strip length (one store
// entry per cycle through the store ports); the next request is taken once the result has moved
// on to the output register, while the output register drains
// reset is asynchronous active low: store valid bits clear at once, no clearing pass
module led_strip_frame_encoder_unit #(
	parameter int MAX_LEDS    = 64,
	parameter int TAIL_FRAMES = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command requests
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  func,
	input  logic [lfe_pkg::IDX_W-1:0]   led_sel,
	input  logic [7:0]                  green,
	input  logic [7:0]                  red,
	input  logic [7:0]                  blue,
	// results
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic [lfe_pkg::SYM_W-1:0]   symbol,
	output logic                        symbol_valid,
	output logic                        last,
	// strip length register write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lfe_pkg::CNT_W-1:0]   cfg_data
);

	logic [lfe_pkg::CNT_W-1:0]   num_leds_q;
	lfe_pkg::item_t              item;
	lfe_pkg::cs_req_t            cs_req;
	logic [lfe_pkg::COLOR_W-1:0] cs_rdata;
	logic                        res_valid;
	logic                        res_ready;
	lfe_pkg::result_t            res;
	logic                        out_valid_q;
	lfe_pkg::result_t            out_q;

	// color word packs green in the top byte, then red, then blue
	assign item = {func, led_sel, green, red, blue};

	// config register, always ready; the user must write it only while the block is quiet, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_leds_q <= lfe_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			num_leds_q <= cfg_data;
		end
	end

	// live colors, cleared to zero at reset through valid bits
	lfe_color_store #(
		.MAX_LEDS(MAX_LEDS)
	) u_color_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (cs_req),
		.rdata (cs_rdata)
	);

	// sequencer with the snapshot ram and the serializer pointers
	lfe_ctrl #(
		.MAX_LEDS   (MAX_LEDS),
		.TAIL_FRAMES(TAIL_FRAMES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.num_leds (num_leds_q),
		.cs_req   (cs_req),
		.cs_rdata (cs_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register splits the result side from the sequencer
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign symbol       = out_q.symbol;
	assign symbol_valid = out_q.sym_valid;
	assign last         = out_q.last;

endmodule

// File: sv/lfe_checker.sv
// lfe_checker: port-level assertions on the led strip frame encoder, bound to the top level
// depends on lfe_pkg and led_strip_frame_encoder_unit
module lfe_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [2:0]                  func,
	input logic [lfe_pkg::IDX_W-1:0]   led_sel,
	input logic [7:0]                  green,
	input logic [7:0]                  red,
	input logic [7:0]                  blue,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        status,
	input logic [lfe_pkg::SYM_W-1:0]   symbol,
	input logic                        symbol_valid,
	input logic                        last,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [lfe_pkg::CNT_W-1:0]   cfg_data
);

	// a waiting result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// an error never carries a frame
	a_err_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !symbol_valid && !last && symbol == lfe_pkg::SYM_TAIL)
		else $error("error result carries a frame");

	// final frame is a valid tail frame
	a_last_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> symbol_valid && symbol == lfe_pkg::SYM_TAIL)
		else $error("last on a non-tail frame");

	// only the three line codes appear
	a_sym_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> symbol == lfe_pkg::SYM_TAIL || symbol == lfe_pkg::SYM_ONE
		              || symbol == lfe_pkg::SYM_ZERO)
		else $error("illegal line symbol");

endmodule

bind led_strip_frame_encoder_unit lfe_checker u_lfe_checker (.*);

// File: tb/tb_led_strip_frame_encoder_unit.sv
// self-checking bench for the led strip frame encoder: random commands, internal predictor
// depends on lfe_pkg and led_strip_frame_encoder_unit
module tb_led_strip_frame_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEDS    = 64;
	localparam int TAIL_FRAMES = 10;
	localparam int TOTAL_ITEMS = 950;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// command request channel
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic [2:0]                 func      = '0;
	logic [lfe_pkg::IDX_W-1:0]  led_sel   = '0;
	logic [7:0]                 green     = '0;
	logic [7:0]                 red       = '0;
	logic [7:0]                 blue      = '0;

	// result channel
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       status;
	logic [lfe_pkg::SYM_W-1:0]  symbol;
	logic                       symbol_valid;
	logic                       last;

	// strip length write channel
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [lfe_pkg::CNT_W-1:0]  cfg_data  = '0;

	led_strip_frame_encoder_unit #(
		.MAX_LEDS(MAX_LEDS),
		.TAIL_FRAMES(TAIL_FRAMES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.led_sel(led_sel),
		.green(green),
		.red(red),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.symbol(symbol),
		.symbol_valid(symbol_valid),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// requests waiting to be driven, and results owed by the block
	lfe_pkg::item_t   pending_requests[$];
	lfe_pkg::result_t expected_frames[$];
	int      mismatches   = 0;
	int      results_seen = 0;
	int      queued       = 0;
	bit      idle_on      = 1'b1;
	bit      held_once    = 1'b0;

	// predictor state: color store, refresh snapshot and serializer pointers
	logic [lfe_pkg::COLOR_W-1:0] strip_colors[MAX_LEDS];
	logic [lfe_pkg::COLOR_W-1:0] snap_colors[MAX_LEDS];
	logic [lfe_pkg::CNT_W-1:0]   strip_len = 7'd1;
	int                          snap_len  = 0;
	lfe_pkg::phase_t             refresh_phase = lfe_pkg::PH_IDLE;
	int                          led_ptr   = 0;
	int                          bit_ptr   = 0;
	int                          tail_cnt  = 0;

	// generator side: pulls still owed to finish the refresh in flight
	int pulls_left = 0;

	// works out the one result of a request and advances the predicted state
	function automatic lfe_pkg::result_t predict_frame_result(lfe_pkg::item_t rq);
		lfe_pkg::result_t            r;
		logic [lfe_pkg::COLOR_W-1:0] c;
		r = '0;
		r.status = lfe_pkg::STATUS_OK;
		r.symbol = lfe_pkg::SYM_TAIL;
		case (lfe_pkg::func_t'(rq.func))
			lfe_pkg::FN_SET_ONE: begin
				if (rq.idx >= MAX_LEDS)
					r.status = lfe_pkg::STATUS_ERR;
				else
					strip_colors[rq.idx] = rq.color;
			end
			lfe_pkg::FN_SET_ALL, lfe_pkg::FN_LIGHT_ONE: begin
				if (strip_len > MAX_LEDS)
					r.status = lfe_pkg::STATUS_ERR;
				else
					for (int n = 0; n < strip_len; n++)
						strip_colors[n] = (rq.func == lfe_pkg::FN_SET_ALL || n == rq.idx)
							? rq.color : '0;
			end
			lfe_pkg::FN_START: begin
				if (refresh_phase != lfe_pkg::PH_IDLE || strip_len == 0
				    || strip_len > MAX_LEDS) begin
					r.status = lfe_pkg::STATUS_ERR;
				end else begin
					for (int n = 0; n < strip_len; n++)
						snap_colors[n] = strip_colors[n];
					snap_len      = strip_len;
					refresh_phase = lfe_pkg::PH_DATA;
					led_ptr       = 0;
					bit_ptr       = 0;
					tail_cnt      = 0;
				end
			end
			lfe_pkg::FN_PULL: begin
				if (refresh_phase == lfe_pkg::PH_DATA) begin
					// green, red, blue, msb first
					c = snap_colors[led_ptr];
					r.symbol    = c[lfe_pkg::BITS_PER_LED-1-bit_ptr] ? lfe_pkg::SYM_ONE
					                                                 : lfe_pkg::SYM_ZERO;
					r.sym_valid = 1'b1;
					bit_ptr++;
					if (bit_ptr >= lfe_pkg::BITS_PER_LED) begin
						bit_ptr = 0;
						led_ptr++;
						if (led_ptr >= snap_len) begin
							led_ptr       = 0;
							refresh_phase = lfe_pkg::PH_TAIL;
							tail_cnt      = 0;
						end
					end
				end else if (refresh_phase == lfe_pkg::PH_TAIL) begin
					r.sym_valid = 1'b1;
					tail_cnt++;
					if (tail_cnt >= TAIL_FRAMES) begin
						r.last        = 1'b1;
						tail_cnt      = 0;
						refresh_phase = lfe_pkg::PH_IDLE;
					end
				end else begin
					// pull with nothing to send
					r.status = lfe_pkg::STATUS_ERR;
				end
			end
			default: r.status = lfe_pkg::STATUS_ERR;
		endcase
		return r;
	endfunction

	// driver: offers queued requests, draws a gap after each one
	int             send_gap = 0;
	lfe_pkg::item_t next_req;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_frames.push_back(predict_frame_result(
					'{func: func, idx: led_sel, color: {green, red, blue}}));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_req  = pending_requests.pop_front();
					func      <= next_req.func;
					led_sel   <= next_req.idx;
					green     <= next_req.color[23:16];
					red       <= next_req.color[15:8];
					blue      <= next_req.color[7:0];
					in_valid  <= 1'b1;
					send_gap  <= idle_on ? $urandom_range(0, 6) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one compare per field against the oldest owed result
	task automatic check_frame_result();
		lfe_pkg::result_t e;
		results_seen++;
		if (expected_frames.size() == 0) begin
			mismatches++;
			$display("%0t: result with no request owed: status %0d symbol %0d valid %0d last %0d",
				$time, status, symbol, symbol_valid, last);
			return;
		end
		e = expected_frames.pop_front();
		if (status !== e.status) begin
			mismatches++;
			$display("%0t: status expected %0d actual %0d", $time, e.status, status);
		end
		if (symbol !== e.symbol) begin
			mismatches++;
			$display("%0t: symbol expected %0d actual %0d", $time, e.symbol, symbol);
		end
		if (symbol_valid !== e.sym_valid) begin
			mismatches++;
			$display("%0t: symbol_valid expected %0d actual %0d", $time, e.sym_valid,
				symbol_valid);
		end
		if (last !== e.last) begin
			mismatches++;
			$display("%0t: last expected %0d actual %0d", $time, e.last, last);
		end
	endtask

	// monitor: random stalls, plus one long hold-off while requests keep coming
	int stall_left = 0;
	int stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready)
				check_frame_result();
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= (stall_left == 1);
			end else if (out_valid && out_ready) begin
				if (!held_once && results_seen >= 100 && pending_requests.size() > 20) begin
					// long hold-off so the block backs up into its input
					stall     = 200;
					held_once = 1'b1;
				end else begin
					stall = idle_on ? $urandom_range(0, 6) : 0;
				end
				stall_left <= stall;
				out_ready  <= (stall == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic lfe_pkg::item_t make_request(logic [2:0] f, int idx, logic [7:0] g,
			logic [7:0] r, logic [7:0] b);
		lfe_pkg::item_t rq;
		rq.func  = f;
		rq.idx   = idx[lfe_pkg::IDX_W-1:0];
		rq.color = {g, r, b};
		return rq;
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// store write with an index near the strip length, inside the store, or anywhere
	function automatic lfe_pkg::item_t make_store_write(int cnt);
		int   idx;
		logic [2:0] f;
		f = 3'($urandom_range(0, 2));
		case ($urandom_range(0, 3))
			0, 1: idx = $urandom_range(0, (cnt < MAX_LEDS) ? cnt + 1 : MAX_LEDS);
			2: idx = $urandom_range(0, MAX_LEDS - 1);
			default: idx = $urandom_range(0, 255);
		endcase
		return make_request(f, idx, pick_level(), pick_level(), pick_level());
	endfunction

	task automatic push_req(lfe_pkg::item_t rq);
		pending_requests.push_back(rq);
		queued++;
	endtask

	// exactly n_items requests: refreshes that fit the budget with writes mixed in,
	// some stray starts, pulls and bad codes
	task automatic queue_phase(int cnt, int n_items);
		int emitted;
		int r;
		int left;
		int need;
		emitted = 0;
		need = (cnt >= 1 && cnt <= MAX_LEDS) ? lfe_pkg::BITS_PER_LED * cnt + TAIL_FRAMES : 0;
		while (emitted < n_items || pulls_left > 0) begin
			r    = $urandom_range(0, 99);
			left = n_items - emitted;
			if (pulls_left > 0 && (r < 75 || left <= pulls_left)) begin
				push_req(make_request(lfe_pkg::FN_PULL, 0, 0, 0, 0));
				pulls_left--;
			end else if (pulls_left == 0 && r < 30 && need < left) begin
				push_req(make_request(lfe_pkg::FN_START, $urandom_range(0, 255), 0, 0, 0));
				pulls_left = need;
			end else if (r < 92) begin
				push_req(make_store_write(cnt));
			end else if (r < 96) begin
				// pull that may land on an idle block
				push_req(make_request(lfe_pkg::FN_PULL, $urandom_range(0, 255),
					pick_level(), pick_level(), pick_level()));
				if (pulls_left > 0)
					pulls_left--;
			end else if (r < 98 && (pulls_left > 0 || need < left)) begin
				// a start is refused while a refresh runs, else it opens a new one
				push_req(make_request(lfe_pkg::FN_START, 0, 0, 0, 0));
				if (pulls_left == 0)
					pulls_left = need;
			end else begin
				push_req(make_request(3'($urandom_range(5, 7)),
					$urandom_range(0, 255), pick_level(), pick_level(), pick_level()));
			end
			emitted++;
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || expected_frames.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_strip_len(logic [lfe_pkg::CNT_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		strip_len = v;
		cfg_valid <= 1'b0;
	endtask

	// reset once at the start
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// stimulus: directed opening at the reset length, then random phases
	int cnt;
	int budget;
	initial begin
		for (int n = 0; n < MAX_LEDS; n++) begin
			strip_colors[n] = '0;
			snap_colors[n]  = '0;
		end
		@(posedge arst_n);
		// pull while idle, unknown codes
		push_req(make_request(lfe_pkg::FN_PULL, 0, 0, 0, 0));
		push_req(make_request(3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		push_req(make_request(3'd6, 0, 0, 0, 0));
		push_req(make_request(3'd7, 8'hAA, 8'h55, 8'hAA, 8'h55));
		// set one at the edges of the store and past it
		push_req(make_request(lfe_pkg::FN_SET_ONE, 0, 8'hFF, 8'h00, 8'hFF));
		push_req(make_request(lfe_pkg::FN_SET_ONE, MAX_LEDS - 1, 8'h00, 8'hFF, 8'h00));
		push_req(make_request(lfe_pkg::FN_SET_ONE, MAX_LEDS, 8'hFF, 8'hFF, 8'hFF));
		push_req(make_request(lfe_pkg::FN_SET_ONE, 255, 8'hFF, 8'hFF, 8'hFF));
		// set all, light one past the strip length clears, then light one in range
		push_req(make_request(lfe_pkg::FN_SET_ALL, 0, 8'h5A, 8'hA5, 8'h3C));
		push_req(make_request(lfe_pkg::FN_LIGHT_ONE, 200, 8'hFF, 8'hFF, 8'hFF));
		push_req(make_request(lfe_pkg::FN_LIGHT_ONE, 0, 8'h81, 8'h42, 8'hC3));
		// refresh with a refused start and writes while it runs
		push_req(make_request(lfe_pkg::FN_START, 0, 0, 0, 0));
		push_req(make_request(lfe_pkg::FN_PULL, 0, 0, 0, 0));
		push_req(make_request(lfe_pkg::FN_PULL, 0, 0, 0, 0));
		push_req(make_request(lfe_pkg::FN_START, 0, 0, 0, 0));
		push_req(make_request(lfe_pkg::FN_SET_ONE, 0, 8'h00, 8'h00, 8'h00));
		push_req(make_request(lfe_pkg::FN_SET_ALL, 0, 8'hFF, 8'hFF, 8'hFF));
		push_req(make_request(lfe_pkg::FN_PULL, 0, 0, 0, 0));
		pulls_left = lfe_pkg::BITS_PER_LED + TAIL_FRAMES - 3;

		for (int p = 0; queued < TOTAL_ITEMS; p++) begin
			case (p)
				0: cnt = 1;
				1: cnt = 0;
				2: cnt = 127;
				3: cnt = MAX_LEDS;
				4: cnt = MAX_LEDS + 1;
				5: cnt = 2;
				default: cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 6)
					: $urandom_range(1, 4);
			endcase
			if (p != 0) begin
				wait_drained();
				repeat (4) @(negedge clk);
				write_strip_len(lfe_pkg::CNT_W'(cnt));
			end
			// some phases run flat out, the rest idle at random
			idle_on = (p % 4 != 1);
			// room for one refresh and some writes where a refresh is short enough
			budget = lfe_pkg::BITS_PER_LED * cnt + TAIL_FRAMES + 25;
			if (cnt < 1 || cnt > MAX_LEDS || budget > 200)
				budget = 40;
			if (budget > TOTAL_ITEMS - queued)
				budget = TOTAL_ITEMS - queued;
			queue_phase(cnt, budget);
		end

		wait_drained();
		repeat (80) @(negedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
sv/lfe_pkg.sv
sv/lfe_ram.sv
sv/lfe_color_store.sv
sv/lfe_ctrl.sv
sv/led_strip_frame_encoder_unit.sv
sv/lfe_checker.sv
tb/tb_led_strip_frame_encoder_unit.sv
